[rtl/rns_pkg.sv]
// ----------------------------------------------------------------------------
// rns_pkg
// Shared types, widths and helpers for the online-trained ReLU neuron.
// ----------------------------------------------------------------------------
package rns_pkg;

  localparam int NUM_FEATURES = 6;
  localparam int FEAT_W       = 16;
  localparam int WORD_W       = 32;
  localparam int PROD_W       = WORD_W + FEAT_W;
  localparam int SUM_W        = PROD_W + $clog2(NUM_FEATURES);
  localparam int FRAC_SHIFT   = 8;
  localparam int ACC_W        = SUM_W - FRAC_SHIFT + 1;
  localparam int RATE_W       = 24;
  localparam int PRED_W       = 31;
  localparam int SAT_W        = 48;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1678);

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [PRED_W-1:0]        pred_t;
  typedef logic [RATE_W-1:0]        rate_t;
  typedef logic signed [SAT_W-1:0]  wide_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam wide_t WIDE_MAX = 48'sh0000_7FFF_FFFF;
  localparam wide_t WIDE_MIN = 48'shFFFF_8000_0000;
  localparam pred_t PRED_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic mul_en;
    logic sel_step;
    logic upd_en;
  } lane_ctrl_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_ERR  = 7'b0001000,
    S_STEP = 7'b0010000,
    S_LMUL = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;

  function automatic word_t sat_word(input wide_t v);
    word_t r;
    if (v > WIDE_MAX) begin
      r = WORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/rns_if.sv]
// ----------------------------------------------------------------------------
// rns_if
// Channel interfaces: input items, results and the step-size write port.
// ----------------------------------------------------------------------------
interface rns_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] feature_0;
  logic signed [15:0] feature_1;
  logic signed [15:0] feature_2;
  logic signed [15:0] feature_3;
  logic signed [15:0] feature_4;
  logic signed [15:0] feature_5;
  logic signed [15:0] target_value;

  modport source (output valid, op, feature_0, feature_1, feature_2, feature_3,
                  feature_4, feature_5, target_value, input ready);
  modport sink   (input valid, op, feature_0, feature_1, feature_2, feature_3,
                  feature_4, feature_5, target_value, output ready);
endinterface

interface rns_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        prediction;
  logic signed [31:0] train_error;

  modport source (output valid, prediction, train_error, input ready);
  modport sink   (input valid, prediction, train_error, output ready);
endinterface

interface rns_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] step_size;

  modport source (output valid, step_size, input ready);
  modport sink   (input valid, step_size, output ready);
endinterface

[rtl/rns_lane.sv]
// ----------------------------------------------------------------------------
// rns_lane
// One weight lane: holds a weight, shares one multiplier between the dot
// product term and the update term, and applies the saturating update.
// ----------------------------------------------------------------------------
module rns_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  rns_pkg::lane_ctrl_t ctrl,
  input  rns_pkg::feat_t      feature,
  input  rns_pkg::word_t      step,
  output rns_pkg::prod_t      prod
);
  import rns_pkg::*;

  word_t weight_r, weight_nxt;
  prod_t prod_r, prod_nxt;
  word_t mul_a;
  wide_t upd_sum;

  always_comb begin
    mul_a    = ctrl.sel_step ? step : weight_r;
    prod_nxt = prod_r;
    if (ctrl.mul_en) begin
      prod_nxt = PROD_W'(mul_a) * PROD_W'(feature);
    end
  end

  always_comb begin
    upd_sum    = SAT_W'(weight_r) + SAT_W'($signed(prod_r[PROD_W-1:FRAC_SHIFT]));
    weight_nxt = weight_r;
    if (ctrl.upd_en) begin
      weight_nxt = sat_word(upd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[rtl/rns_merge.sv]
// ----------------------------------------------------------------------------
// rns_merge
// Merge stage: sums the lane products, drops the extra fraction bits with
// round-down and adds the bias.
// ----------------------------------------------------------------------------
module rns_merge (
  input  logic           clk,
  input  logic           en,
  input  rns_pkg::prod_t prod [rns_pkg::NUM_FEATURES],
  input  rns_pkg::word_t bias,
  output rns_pkg::acc_t  acc
);
  import rns_pkg::*;

  logic signed [SUM_W-1:0] dot;
  acc_t acc_r, acc_nxt;

  always_comb begin
    dot = '0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      dot = dot + SUM_W'(prod[i]);
    end
    acc_nxt = ACC_W'($signed(dot[SUM_W-1:FRAC_SHIFT])) + ACC_W'(bias);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/relu_neuron_online_sgd.sv]
// ----------------------------------------------------------------------------
// relu_neuron_online_sgd
// Six-input ReLU neuron with online SGD training of weights and bias.
//
//   channel  direction  transaction
//   in_ch    sink       op, feature_0..feature_5, target_value
//   out_ch   source     prediction, train_error
//   cfg_ch   sink       step_size (always ready)
//
// A predict item steps through S_MUL, S_SUM and S_ERR, a train item goes on
// through S_STEP, S_LMUL and S_UPD, before the result register is loaded; the
// lane multipliers are used twice per train item (dot product, then update
// term) with one rate multiply between them.
// The next item is accepted in the cycle its predecessor's result is loaded.
// Reset clears weights and bias to zero and the rate to 1678.
// A stalled result holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module relu_neuron_online_sgd (
  input  logic      clk,
  input  logic      rst_n,
  rns_in_if.sink    in_ch,
  rns_out_if.source out_ch,
  rns_cfg_if.sink   cfg_ch
);
  import rns_pkg::*;

  state_t     state_r, state_nxt;
  feat_t      feat_r [NUM_FEATURES];
  feat_t      feat_in [NUM_FEATURES];
  feat_t      tgt_r;
  logic       op_r;
  pred_t      pred_r, pred_nxt;
  word_t      err_r, err_nxt;
  word_t      step_r;
  word_t      bias_r, bias_nxt;
  rate_t      rate_r;
  logic       out_valid_r, out_valid_nxt;
  pred_t      out_pred_r;
  word_t      out_err_r;
  logic       out_free;
  logic       in_take;
  logic       done_load;
  lane_ctrl_t lane_ctrl;
  prod_t      prod [NUM_FEATURES];
  acc_t       acc;
  logic signed [WORD_W:0]               err_ext;
  logic signed [RATE_W+WORD_W:0]        step_prod;
  logic                                 acc_big;

  assign feat_in[0] = in_ch.feature_0;
  assign feat_in[1] = in_ch.feature_1;
  assign feat_in[2] = in_ch.feature_2;
  assign feat_in[3] = in_ch.feature_3;
  assign feat_in[4] = in_ch.feature_4;
  assign feat_in[5] = in_ch.feature_5;

  assign cfg_ch.ready = 1'b1;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign done_load   = (state_r == S_ERR && op_r == OP_PREDICT) || (state_r == S_UPD);
  assign in_ch.ready = (state_r == S_IDLE) || (done_load && out_free);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign lane_ctrl.mul_en   = (state_r == S_MUL) || (state_r == S_LMUL);
  assign lane_ctrl.sel_step = (state_r == S_LMUL);
  assign lane_ctrl.upd_en   = (state_r == S_UPD) && out_free;

  for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
    rns_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .feature (feat_r[g]),
      .step    (step_r),
      .prod    (prod[g])
    );
  end

  rns_merge u_merge (
    .clk  (clk),
    .en   (state_r == S_SUM),
    .prod (prod),
    .bias (bias_r),
    .acc  (acc)
  );

  // ReLU with saturation, then error against the target
  always_comb begin
    acc_big = |acc[ACC_W-2:PRED_W];
    if (acc[ACC_W-1]) begin
      pred_nxt = '0;
    end else if (acc_big) begin
      pred_nxt = PRED_MAX;
    end else begin
      pred_nxt = acc[PRED_W-1:0];
    end
    err_ext = {{(WORD_W-FEAT_W-FRAC_SHIFT+1){tgt_r[FEAT_W-1]}}, tgt_r, 8'h00}
              - {2'b00, pred_nxt};
    if (err_ext[WORD_W] != err_ext[WORD_W-1]) begin
      err_nxt = err_ext[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      err_nxt = err_ext[WORD_W-1:0];
    end
  end

  assign step_prod = (RATE_W+WORD_W+1)'($signed({1'b0, rate_r}))
                     * (RATE_W+WORD_W+1)'(err_r);

  always_comb begin
    bias_nxt = bias_r;
    if (lane_ctrl.upd_en) begin
      bias_nxt = sat_word(SAT_W'(bias_r) + SAT_W'(step_r));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ERR;
      S_ERR: begin
        if (op_r == OP_TRAIN) begin
          state_nxt = S_STEP;
        end else if (out_free) begin
          state_nxt = in_take ? S_MUL : S_IDLE;
        end
      end
      S_STEP: state_nxt = S_LMUL;
      S_LMUL: state_nxt = S_UPD;
      S_UPD: begin
        if (out_free) begin
          state_nxt = in_take ? S_MUL : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_load && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bias_r      <= '0;
      rate_r      <= RATE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bias_r      <= bias_nxt;
      if (cfg_ch.valid) begin
        rate_r <= cfg_ch.step_size;
      end
    end
  end

  // Hold the item, the error and the step for the duration of the item
  always_ff @(posedge clk) begin
    if (in_take) begin
      feat_r <= feat_in;
      tgt_r  <= in_ch.target_value;
      op_r   <= in_ch.op;
    end
    if (state_r == S_ERR) begin
      pred_r <= pred_nxt;
      err_r  <= err_nxt;
    end
    if (state_r == S_STEP) begin
      step_r <= step_prod[RATE_W+WORD_W-1:RATE_W];
    end
    if (done_load && out_free) begin
      out_pred_r <= (state_r == S_ERR) ? pred_nxt : pred_r;
      out_err_r  <= (state_r == S_ERR) ? '0 : err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prediction  = out_pred_r;
  assign out_ch.train_error = out_err_r;

  a_bias_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && bias_r != $past(bias_r)) |-> $past(state_r == S_UPD))
    else $error("bias changed outside the update step");

  a_predict_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR && op_r == OP_PREDICT) |-> !lane_ctrl.upd_en && bias_nxt == bias_r)
    else $error("predict transaction altered the weights");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ERR || state_r == S_UPD))
    else $error("result raised without a finished transaction");

  a_train_goes_to_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR && op_r == OP_TRAIN) |=> state_r == S_STEP)
    else $error("train transaction skipped the rate step");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the online-trained ReLU neuron. A queue-fed driver
// and a monitor with random gaps and back-pressure surround the block; a
// bit-exact fixed-point neuron model tracks weights, bias and step size,
// and every result transaction is compared against it field by field.
// ----------------------------------------------------------------------------
module tb;
  import rns_pkg::*;

  localparam rate_t RATE_MAX  = 24'hFF_FFFF;

  typedef struct {
    logic  op;
    feat_t feature [NUM_FEATURES];
    feat_t target_value;
  } sample_t;

  typedef struct packed {
    pred_t prediction;
    word_t train_error;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  rns_in_if  in_ch ();
  rns_out_if out_ch ();
  rns_cfg_if cfg_ch ();

  relu_neuron_online_sgd i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sample_t queued_samples [$];
  result_t predicted_results [$];

  word_t weights [NUM_FEATURES];
  word_t bias_acc;
  rate_t rate_reg;
  int    teacher_w [NUM_FEATURES];
  int    gap_pct;

  int n_errors;
  int n_items;
  int n_train;
  int n_rates;
  int n_zero_pred;
  int n_sat_pred;
  int n_sat_err;
  int n_checked;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  function automatic word_t clamp_word(input longint v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = WORD_MAX;
    end else if (v < -64'sd2147483648) begin
      r = WORD_MIN;
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  // Work out one result transaction and apply the training update.
  function automatic void neuron_step(input sample_t s);
    longint  dot;
    longint  acc;
    longint  pred_l;
    longint  err_full;
    longint  step_v;
    word_t   err_w;
    result_t r;
    int      i;
    dot = 0;
    for (i = 0; i < NUM_FEATURES; i++) begin
      dot += longint'(weights[i]) * longint'(s.feature[i]);
    end
    acc = (dot >>> FRAC_SHIFT) + longint'(bias_acc);
    if (acc <= 0) begin
      pred_l = 0;
      n_zero_pred++;
    end else if (acc > 64'sd2147483647) begin
      pred_l = 64'sd2147483647;
      n_sat_pred++;
    end else begin
      pred_l = acc;
    end
    err_w = '0;
    if (s.op == OP_TRAIN) begin
      n_train++;
      err_full = longint'(s.target_value) * 256 - pred_l;
      if (err_full > 64'sd2147483647 || err_full < -64'sd2147483648) begin
        n_sat_err++;
      end
      err_w = clamp_word(err_full);
      step_v = (longint'(rate_reg) * longint'(err_w)) >>> RATE_W;
      for (i = 0; i < NUM_FEATURES; i++) begin
        weights[i] = clamp_word(longint'(weights[i])
                                + ((step_v * longint'(s.feature[i])) >>> FRAC_SHIFT));
      end
      bias_acc = clamp_word(longint'(bias_acc) + step_v);
    end
    r.prediction  = pred_t'(pred_l);
    r.train_error = err_w;
    predicted_results.push_back(r);
    n_items++;
  endfunction

  function automatic sample_t make_sample(input logic op, input feat_t f_even,
                                          input feat_t f_odd, input feat_t tgt);
    sample_t s;
    int      i;
    s.op = op;
    for (i = 0; i < NUM_FEATURES; i++) begin
      s.feature[i] = (i % 2 == 0) ? f_even : f_odd;
    end
    s.target_value = tgt;
    return s;
  endfunction

  function automatic feat_t random_value();
    feat_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = feat_t'($urandom);
      4, 5, 6:    v = feat_t'(int'($urandom_range(2046)) - 1023);
      7:          v = feat_t'(int'($urandom_range(126)) - 63);
      8: begin
        case ($urandom_range(3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7FFF;
          2:       v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Teacher mode: nine in ten targets come from a hidden linear map, so training converges.
  function automatic sample_t random_sample(input bit follow_teacher);
    sample_t s;
    longint  sum;
    int      i;
    sum = 0;
    if (follow_teacher && $urandom_range(9) != 0) begin
      s.op = ($urandom_range(99) < 85) ? OP_TRAIN : OP_PREDICT;
      for (i = 0; i < NUM_FEATURES; i++) begin
        s.feature[i] = feat_t'(int'($urandom_range(2046)) - 1023);
        sum += longint'(teacher_w[i]) * longint'(s.feature[i]);
      end
      s.target_value = feat_t'(sum >>> FRAC_SHIFT);
    end else begin
      s.op = ($urandom_range(99) < 70) ? OP_TRAIN : OP_PREDICT;
      for (i = 0; i < NUM_FEATURES; i++) begin
        s.feature[i] = random_value();
      end
      s.target_value = random_value();
    end
    return s;
  endfunction

  task automatic write_rate(input rate_t v);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.step_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rate_reg = v;
    n_rates++;
  endtask

  task automatic wait_idle();
    while (queued_samples.size() != 0 || predicted_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: hold the head item until accepted, then advance.
  always @(posedge clk) begin : drive_inputs
    logic    send;
    sample_t head;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        neuron_step(queued_samples.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        send = (queued_samples.size() != 0) && ($urandom_range(99) >= gap_pct);
        in_ch.valid <= send;
        if (send) begin
          head = queued_samples[0];
          in_ch.op           <= head.op;
          in_ch.feature_0    <= head.feature[0];
          in_ch.feature_1    <= head.feature[1];
          in_ch.feature_2    <= head.feature[2];
          in_ch.feature_3    <= head.feature[3];
          in_ch.feature_4    <= head.feature[4];
          in_ch.feature_5    <= head.feature[5];
          in_ch.target_value <= head.target_value;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (predicted_results.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.prediction !== want.prediction) begin
            report_mismatch($sformatf("result %0d prediction %0d, wanted %0d",
                                      n_checked, out_ch.prediction, want.prediction));
          end
          if (out_ch.train_error !== want.train_error) begin
            report_mismatch($sformatf("result %0d train_error %0d, wanted %0d",
                                      n_checked, out_ch.train_error, want.train_error));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  initial begin : stimulus
    int    p;
    int    k;
    int    count;
    bit    teach;
    rate_t rate_v;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_PREDICT;
    in_ch.feature_0    = '0;
    in_ch.feature_1    = '0;
    in_ch.feature_2    = '0;
    in_ch.feature_3    = '0;
    in_ch.feature_4    = '0;
    in_ch.feature_5    = '0;
    in_ch.target_value = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.step_size   = '0;
    gap_pct            = 34;
    rate_reg           = RATE_RESET;
    bias_acc           = '0;
    for (k = 0; k < NUM_FEATURES; k++) begin
      weights[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset rate: small moves from zero weights.
    @(negedge clk);
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sd0, 16'sd0, 16'sd0));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sh7FFF, 16'sh8000, 16'sd0));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sd1, -16'sd1, 16'sd1));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sh8000, 16'sh8000, 16'sd0));
    wait_idle();

    // Full rate: drive weights, bias, prediction and error into saturation.
    write_rate(RATE_MAX);
    @(negedge clk);
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sh7FFF, 16'sh7FFF, 16'sd0));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sh8000, 16'sh8000, 16'sd0));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sd0, 16'sd0, 16'sh7FFF));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sh7FFF, 16'sh8000, 16'sd0));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sd256, -16'sd256, 16'sd100));
    queued_samples.push_back(make_sample(OP_TRAIN, 16'sh7FFF, 16'sh8000, 16'sh8000));
    queued_samples.push_back(make_sample(OP_PREDICT, 16'sd0, 16'sd0, 16'sd0));
    wait_idle();

    for (p = 0; p < 8; p++) begin
      teach = 1'b0;
      count = 130;
      gap_pct = 34;
      case (p)
        0:       rate_v = rate_t'($urandom);
        1:       rate_v = '0;
        2: begin
          rate_v  = RATE_MAX;
          gap_pct = 0;
          count   = 240;
        end
        3:       rate_v = RATE_RESET;
        4: begin
          rate_v = rate_t'(24'h01_0000);
          teach  = 1'b1;
        end
        5: begin
          rate_v = rate_t'($urandom_range(65535, 1));
          teach  = 1'b1;
        end
        6:       rate_v = rate_t'(1);
        default: rate_v = rate_t'($urandom);
      endcase
      for (k = 0; k < NUM_FEATURES; k++) begin
        teacher_w[k] = int'($urandom_range(1024)) - 512;
      end
      write_rate(rate_v);
      @(negedge clk);
      for (k = 0; k < count; k++) begin
        queued_samples.push_back(random_sample(teach));
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("%0d items (%0d train) checked over %0d step-size settings",
             n_items, n_train, n_rates);
    $display("%0d zero predictions, %0d saturated predictions, %0d saturated errors",
             n_zero_pred, n_sat_pred, n_sat_err);
    if (n_errors == 0 && predicted_results.size() == 0) begin
      $display("relu_neuron_online_sgd: match");
    end else begin
      $display("relu_neuron_online_sgd: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("relu_neuron_online_sgd: mismatch");
    $finish;
  end

endmodule
